@@ hdl/light_sensor_autorange_quantizer_defines.svh @@
// Assertion macros used by the quantizer top level.
// No dependencies; included by the files that carry assertions.
`ifndef LIGHT_SENSOR_AUTORANGE_QUANTIZER_DEFINES_SVH
`define LIGHT_SENSOR_AUTORANGE_QUANTIZER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LSAQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LSAQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/lsaq_pkg.sv @@
// Constants, register indexes and table functions for the light sensor quantizer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lsaq_pkg;

  localparam int RAW_W   = 16;
  localparam int SCALE_W = 10;
  localparam int GRADE_W = 2;
  localparam int MLUX_W  = 27;
  localparam int STEP_W  = 17;
  localparam int CNT_W   = $clog2(MLUX_W);
  localparam int IDX_W   = 2;

  // Number of decade levels; the step tables themselves hold seven.
  localparam int LEVELS    = 7;
  localparam int LEVEL_TOP = (LEVELS - 1 > 15) ? 15 : LEVELS - 1;
  localparam int LVL_W     = 4;

  localparam logic [MLUX_W-1:0] LOW_SWITCH  = MLUX_W'(20000);
  localparam logic [MLUX_W-1:0] HIGH_SWITCH = MLUX_W'(980000);
  localparam logic [MLUX_W-1:0] MLUX_MAX    = {MLUX_W{1'b1}};

  localparam logic [IDX_W-1:0] REG_ACCURACY   = 2'd0;
  localparam logic [IDX_W-1:0] REG_RANGE      = 2'd1;
  localparam logic [IDX_W-1:0] REG_RESOLUTION = 2'd2;

  localparam logic [GRADE_W-1:0] GRADE_HIGH   = 2'd0;
  localparam logic [GRADE_W-1:0] GRADE_MEDIUM = 2'd1;

  localparam logic [GRADE_W-1:0] GRADE_RESET = 2'd2;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 10'd1;

  // Upper bound of decade level i: 100 * 10^i.
  function automatic logic [63:0] limit_of(input logic [LVL_W-1:0] i);
    logic [63:0] lim;
    case (i)
      4'd0:    lim = 64'd100;
      4'd1:    lim = 64'd1000;
      4'd2:    lim = 64'd10000;
      4'd3:    lim = 64'd100000;
      4'd4:    lim = 64'd1000000;
      4'd5:    lim = 64'd10000000;
      4'd6:    lim = 64'd100000000;
      4'd7:    lim = 64'd1000000000;
      4'd8:    lim = 64'd10000000000;
      default: lim = 64'd100000000000;
    endcase
    return lim;
  endfunction

  // First level whose bound exceeds the value, else the top level.
  function automatic logic [LVL_W-1:0] level_of(input logic [MLUX_W-1:0] v);
    logic [LVL_W-1:0] lvl;
    lvl = LVL_W'(LEVEL_TOP);
    for (int i = LEVEL_TOP - 1; i >= 0; i--) begin
      if (64'(v) < limit_of(LVL_W'(i))) lvl = LVL_W'(i);
    end
    return lvl;
  endfunction

  // Resolution step for a grade and level; grade three behaves as low.
  function automatic logic [STEP_W-1:0] step_of(input logic [GRADE_W-1:0] grade,
                                                input logic [LVL_W-1:0] lvl);
    logic [2:0]        l;
    logic [STEP_W-1:0] s;
    l = (lvl > 4'd6) ? 3'd6 : lvl[2:0];
    if (grade == GRADE_HIGH) begin
      case (l)
        3'd0:    s = 17'd1;
        3'd1:    s = 17'd10;
        3'd2:    s = 17'd10;
        3'd3:    s = 17'd50;
        3'd4:    s = 17'd100;
        3'd5:    s = 17'd500;
        default: s = 17'd1000;
      endcase
    end else if (grade == GRADE_MEDIUM) begin
      case (l)
        3'd0:    s = 17'd10;
        3'd1:    s = 17'd50;
        3'd2:    s = 17'd500;
        3'd3:    s = 17'd1000;
        3'd4:    s = 17'd2000;
        3'd5:    s = 17'd5000;
        default: s = 17'd10000;
      endcase
    end else begin
      case (l)
        3'd0:    s = 17'd20;
        3'd1:    s = 17'd100;
        3'd2:    s = 17'd2000;
        3'd3:    s = 17'd10000;
        3'd4:    s = 17'd20000;
        3'd5:    s = 17'd50000;
        default: s = 17'd100000;
      endcase
    end
    return s;
  endfunction

endpackage

@@ hdl/lsaq_rem_unit.sv @@
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Depends on lsaq_pkg for the operand widths.
`timescale 1ns / 1ps

module lsaq_rem_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [lsaq_pkg::MLUX_W-1:0]  dividend,
  input  logic [lsaq_pkg::STEP_W-1:0]  divisor,
  output logic                         done,
  output logic [lsaq_pkg::STEP_W-1:0]  rem
);
  import lsaq_pkg::*;

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [MLUX_W-1:0] dvd;
  logic [STEP_W:0]   trial;

  // The divisor is held stable by the caller for the whole iteration.
  assign trial = {rem, dvd[MLUX_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dvd  <= dividend;
        rem  <= '0;
      end else if (busy) begin
        dvd <= {dvd[MLUX_W-2:0], 1'b0};
        if (trial >= {1'b0, divisor}) begin
          rem <= STEP_W'(trial - {1'b0, divisor});
        end else begin
          rem <= trial[STEP_W-1:0];
        end
        if (cnt == CNT_W'(MLUX_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

@@ hdl/light_sensor_autorange_quantizer.sv @@
// Top level of the light sensor auto-ranging quantizer.
// Depends on lsaq_pkg, lsaq_rem_unit and the assertion macro header.
//
//   channel  | handshake                    | payload
//   ---------+------------------------------+---------------------------------------
//   sample   | sample_valid / sample_stall  | raw_count
//   result   | result_valid / result_stall  | mode_switched, gain_mode,
//            |                              | report_valid, reported_mlux
//   config   | cfg_write                    | cfg_index, cfg_data
//
// An item whose converted value changed passes from acceptance through ST_MUL, ST_DECIDE,
// ST_DIV with the bit-serial remainder unit, ST_ROUND and ST_PUSH to the result register.
// An item that switches the mode or repeats the last converted value skips to ST_PUSH.
// One item is in work at a time; a waiting result does not block acceptance.
// Synchronous reset clears the sequencer, the gain mode, the held values and
// restores the configuration registers. A stalled result holds its payload.
`timescale 1ns / 1ps
`include "light_sensor_autorange_quantizer_defines.svh"

module light_sensor_autorange_quantizer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [lsaq_pkg::IDX_W-1:0]    cfg_index,
  input  logic [lsaq_pkg::SCALE_W-1:0]  cfg_data,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  logic [lsaq_pkg::RAW_W-1:0]    raw_count,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic                          mode_switched,
  output logic                          gain_mode,
  output logic                          report_valid,
  output logic [lsaq_pkg::MLUX_W-1:0]   reported_mlux
);
  import lsaq_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DECIDE,
    ST_DIV,
    ST_ROUND,
    ST_PUSH
  } state_t;

  state_t state;

  logic [GRADE_W-1:0] accuracy_grade;
  logic [SCALE_W-1:0] range_scale;
  logic [SCALE_W-1:0] resolution_scale;

  logic               gain_mode_reg;
  logic [MLUX_W-1:0]  last_converted;
  logic [MLUX_W-1:0]  last_reported;

  logic [RAW_W-1:0]   raw;
  logic [MLUX_W-1:0]  value;
  logic [STEP_W-1:0]  step;
  logic               switch_pend;
  logic               report_pend;

  logic               do_switch;
  logic               rem_start;
  logic               rem_done;
  logic [STEP_W-1:0]  rem;
  logic [SCALE_W-1:0] scale;
  logic [MLUX_W:0]    rounded;
  logic [MLUX_W-1:0]  rounded_sat;
  logic               slot_free;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      accuracy_grade   <= GRADE_RESET;
      range_scale      <= SCALE_RESET;
      resolution_scale <= SCALE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ACCURACY:   accuracy_grade   <= cfg_data[GRADE_W-1:0];
        REG_RANGE:      range_scale      <= cfg_data;
        REG_RESOLUTION: resolution_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  assign sample_stall = (state != ST_IDLE);
  assign slot_free    = !result_valid || !result_stall;
  assign scale        = gain_mode_reg ? resolution_scale : range_scale;

  assign do_switch = (!gain_mode_reg && (value < LOW_SWITCH)) ||
                     (gain_mode_reg && (value > HIGH_SWITCH));
  assign rem_start = (state == ST_DECIDE) && !do_switch && (value != last_converted);

  // Round half-down to the step: round up only when the remainder exceeds half a step.
  always_comb begin
    rounded = {1'b0, value} - (MLUX_W + 1)'(rem);
    if (rem > (step >> 1)) rounded = rounded + (MLUX_W + 1)'(step);
    rounded_sat = rounded[MLUX_W] ? MLUX_MAX : rounded[MLUX_W-1:0];
  end

  lsaq_rem_unit u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (value),
    .divisor  (step),
    .done     (rem_done),
    .rem      (rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      gain_mode_reg  <= 1'b0;
      last_converted <= '0;
      last_reported  <= '0;
      result_valid   <= 1'b0;
    end else begin
      if (state == ST_PUSH && slot_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (sample_valid) begin
            raw   <= raw_count;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          value <= MLUX_W'(raw * scale);
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          report_pend <= 1'b0;
          switch_pend <= do_switch;
          if (do_switch) begin
            gain_mode_reg <= !gain_mode_reg;
            state         <= ST_PUSH;
          end else if (value == last_converted) begin
            state <= ST_PUSH;
          end else begin
            last_converted <= value;
            step           <= step_of(accuracy_grade, level_of(value));
            state          <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (rem_done) state <= ST_ROUND;
        end
        ST_ROUND: begin
          report_pend   <= (rounded_sat != last_reported);
          last_reported <= rounded_sat;
          state         <= ST_PUSH;
        end
        ST_PUSH: begin
          if (slot_free) begin
            mode_switched <= switch_pend;
            gain_mode     <= gain_mode_reg;
            report_valid  <= report_pend;
            reported_mlux <= last_reported;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `LSAQ_ASSERT_NOW(a_report_excl_switch, clk, rst, result_valid && report_valid, !mode_switched, "report and mode switch in one item")
  `LSAQ_ASSERT_NOW(a_done_in_div, clk, rst, rem_done, state == ST_DIV, "remainder finished outside the division state")
  `LSAQ_ASSERT_NOW(a_rem_below_step, clk, rst, rem_done, rem < step, "remainder not below the step")
  `LSAQ_ASSERT_NEXT(a_accept_starts, clk, rst, sample_valid && !sample_stall, state == ST_MUL, "accepted item did not start the sequence")

endmodule
